/* rtl/core/dssa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array package
// Request and response layouts, operation and status codes, and the
// default sizes shared by the core modules.
// ----------------------------------------------------------------------------
package dssa_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Entry-count register.
   localparam int                    CSR_WIDTH = 9;
   localparam logic [CSR_WIDTH-1:0]  CSR_RESET = 9'd256;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_POP    = 1'b1;
   localparam logic STACK_ONE = 1'b0;
   localparam logic STACK_TWO = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic               operation;
      logic               which_stack;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
   } rsp_type;

   // Response bookkeeping that travels with the memory read.
   typedef struct packed {
      logic       valid;
      logic       pop_ok;
      logic [1:0] status;
   } rsp_ctl_type;

endpackage

/* rtl/core/dssa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array memory
// Single-port synchronous RAM, one read or one write per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module dssa_ram #(
   parameter int DEPTH      = dssa_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dssa_pkg::DATA_WIDTH_DEFAULT,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic                  we,
   input  logic [AW-1:0]         addr,
   input  logic [DATA_WIDTH-1:0] wdata,
   output logic [DATA_WIDTH-1:0] rdata
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/dssa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array control
// Holds both stack counts and the entry count, checks overflow and underflow,
// and maps each request to a memory address on the snake path.
// ----------------------------------------------------------------------------
module dssa_ctrl #(
   parameter int DEPTH      = dssa_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dssa_pkg::DATA_WIDTH_DEFAULT,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  dssa_pkg::req_type              req,
   input  logic                           csr_write,
   input  logic [dssa_pkg::CSR_WIDTH-1:0] csr_value,
   output logic                           ram_en,
   output logic                           ram_we,
   output logic [AW-1:0]                  ram_addr,
   output logic [DATA_WIDTH-1:0]          ram_wdata,
   output dssa_pkg::rsp_ctl_type          rsp_ctl
);

   localparam int EW      = $clog2(DEPTH + 1);
   localparam int PW      = EW + 1;
   localparam int E_RESET = (DEPTH < int'(dssa_pkg::CSR_RESET)) ? DEPTH
                                                                 : int'(dssa_pkg::CSR_RESET);

   logic [EW-1:0] count_one_ff, count_one_in;
   logic [EW-1:0] count_two_ff, count_two_in;
   logic [EW-1:0] entries_ff, entries_in;
   logic [EW-1:0] evens_ff, evens_in;
   logic [PW-1:0] mirror_ff, mirror_in;
   dssa_pkg::rsp_ctl_type rsp_ctl_ff, rsp_ctl_in;

   logic [31:0]   csr_wide;
   logic [31:0]   entries_wide;
   logic [PW-1:0] total;
   logic          full;
   logic [EW-1:0] sel_count;
   logic          is_pop;
   logic          ok;
   logic [PW-1:0] pos;
   logic [PW-1:0] pos_x2;
   logic [PW-1:0] addr_full;
   logic [95:0]   push_ext;

   // Effective entry count, clamped to one through DEPTH, plus the values
   // the path mapping needs, all settled when the register is written.
   always_comb begin
      csr_wide = 32'(csr_value);
      if (csr_wide == 32'd0) begin
         entries_wide = 32'd1;
      end else if (csr_wide > 32'(DEPTH)) begin
         entries_wide = 32'(DEPTH);
      end else begin
         entries_wide = csr_wide;
      end
      entries_in = EW'(entries_wide);
      evens_in   = EW'((entries_wide + 32'd1) >> 1);
      mirror_in  = PW'((entries_wide << 1) - 32'd1);
   end

   always_comb begin
      is_pop    = (req.operation == dssa_pkg::OP_POP);
      total     = PW'(count_one_ff) + PW'(count_two_ff);
      full      = (total >= PW'(entries_ff));
      sel_count = (req.which_stack == dssa_pkg::STACK_TWO) ? count_two_ff : count_one_ff;
      ok        = is_pop ? (sel_count != '0) : !full;

      // Path position of the entry touched: the next free slot on a push,
      // the top entry on a pop.
      if (req.which_stack == dssa_pkg::STACK_TWO) begin
         pos = is_pop ? (PW'(entries_ff) - PW'(count_two_ff))
                      : (PW'(entries_ff) - PW'(count_two_ff) - PW'(1));
      end else begin
         pos = is_pop ? (PW'(count_one_ff) - PW'(1)) : PW'(count_one_ff);
      end
      pos_x2 = pos << 1;

      // Evens ascend; odds descend from the top, which is 2E-1-2p.
      addr_full = (pos < PW'(evens_ff)) ? pos_x2 : (mirror_ff - pos_x2);

      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      if (accept && ok) begin
         if (req.which_stack == dssa_pkg::STACK_TWO) begin
            count_two_in = is_pop ? (count_two_ff - EW'(1)) : (count_two_ff + EW'(1));
         end else begin
            count_one_in = is_pop ? (count_one_ff - EW'(1)) : (count_one_ff + EW'(1));
         end
      end

      rsp_ctl_in.valid  = accept;
      rsp_ctl_in.pop_ok = is_pop && ok;
      if (ok) begin
         rsp_ctl_in.status = dssa_pkg::ST_OK;
      end else if (is_pop) begin
         rsp_ctl_in.status = dssa_pkg::ST_UNDERFLOW;
      end else begin
         rsp_ctl_in.status = dssa_pkg::ST_OVERFLOW;
      end

      push_ext = {{64{req.push_value[31]}}, req.push_value};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_one_ff <= '0;
         count_two_ff <= '0;
         entries_ff   <= EW'(E_RESET);
         evens_ff     <= EW'((E_RESET + 1) / 2);
         mirror_ff    <= PW'(2 * E_RESET - 1);
         rsp_ctl_ff   <= '0;
      end else begin
         if (csr_write) begin
            count_one_ff <= '0;
            count_two_ff <= '0;
            entries_ff   <= entries_in;
            evens_ff     <= evens_in;
            mirror_ff    <= mirror_in;
         end else begin
            count_one_ff <= count_one_in;
            count_two_ff <= count_two_in;
         end
         rsp_ctl_ff <= rsp_ctl_in;
      end
   end

   assign ram_en    = accept && ok;
   assign ram_we    = accept && ok && !is_pop;
   assign ram_addr  = AW'(addr_full);
   assign ram_wdata = push_ext[DATA_WIDTH-1:0];
   assign rsp_ctl   = rsp_ctl_ff;

   // The two stacks together never claim more entries than are in use.
   assert property (@(posedge clock) disable iff (reset)
      (PW'(count_one_ff) + PW'(count_two_ff)) <= PW'(entries_ff))
      else $error("stack counts exceed the entry count");

   // Every memory access lands inside the entries in use.
   assert property (@(posedge clock) disable iff (reset)
      ram_en |-> (addr_full < PW'(entries_ff)))
      else $error("memory address beyond the entries in use");

   // A response follows each accepted request in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_ctl_ff.valid == $past(accept)))
      else $error("response strobe out of step with accepted requests");

   // A successful push grows the combined fill by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && !csr_write) |=> (PW'(count_one_ff) + PW'(count_two_ff)) ==
                                 $past(total) + PW'(1))
      else $error("push did not advance the fill level");

   // A popped word is only returned with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ctl_ff.pop_ok |-> (rsp_ctl_ff.status == dssa_pkg::ST_OK))
      else $error("pop data flagged with a failing status");

endmodule

/* rtl/core/dual_stack_shared_array_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array
// Two stacks in one single-port memory: stack one runs the snake path
// forward, stack two runs it backward, with overflow and underflow status.
//
//   Channel   Handshake                 Payload
//   request   start high, busy low      req_data  (operation, stack, word)
//   response  rsp_strobe, one cycle     rsp_data  (pop_value, status)
//   csr       csr_valid and csr_ready   csr_wdata (entries in use, 9 bits)
//
// One request per cycle unless busy, answered the cycle after it is taken.
// The single memory port does at most one read or one write per request.
// Reset empties both stacks, sets min(DEPTH, 256) entries; memory is kept.
// busy is high only while a csr write is offered; a csr write empties both
// stacks. The receiver cannot stall: each response is shown for one cycle.
// ----------------------------------------------------------------------------
module dual_stack_shared_array_top #(
   parameter int DEPTH      = dssa_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dssa_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  dssa_pkg::req_type              req_data,
   output logic                           rsp_strobe,
   output dssa_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dssa_pkg::CSR_WIDTH-1:0] csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  accept;
   logic                  csr_write;
   logic                  ram_en;
   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [DATA_WIDTH+63:0] pop_ext;
   dssa_pkg::rsp_ctl_type rsp_ctl;

   // A csr write takes the cycle; requests wait behind it.
   assign csr_ready = 1'b1;
   assign busy      = csr_valid;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = start && !busy;

   dssa_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_write (csr_write),
      .csr_value (csr_wdata),
      .ram_en    (ram_en),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .rsp_ctl   (rsp_ctl)
   );

   dssa_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Popped words are sign-extended from the stored width to 32 bits.
   assign pop_ext = {{64{ram_rdata[DATA_WIDTH-1]}}, ram_rdata};

   always_comb begin
      rsp_strobe         = rsp_ctl.valid;
      rsp_data.status    = rsp_ctl.status;
      rsp_data.pop_value = rsp_ctl.pop_ok ? pop_ext[31:0] : 32'sd0;
   end

endmodule

/* bench/tb_dual_stack_shared_array_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared array testbench
// Drives push and pop requests on both stacks under several entry counts and
// idle patterns. A local predictor of the two snake-path stacks computes
// every response, and each strobed response is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_array_top;

   localparam int DEPTH      = dssa_pkg::DEPTH_DEFAULT;
   localparam int CW         = dssa_pkg::CSR_WIDTH;
   localparam int MAX_CYCLES = 200000;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   dssa_pkg::req_type    req_data;
   logic                 rsp_strobe;
   dssa_pkg::rsp_type    rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CW-1:0]        csr_wdata;

   // Predictor state.
   logic signed [31:0]   shadow_store [DEPTH];
   logic [CW-1:0]        entries_reg;
   int                   depth_one;
   int                   depth_two;

   dssa_pkg::rsp_type pending_results[$];
   int      error_count;
   int      request_count;
   int      overflow_count;
   int      underflow_count;
   int      csr_write_count;

   dual_stack_shared_array_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      repeat (MAX_CYCLES) @(posedge clock);
      $display("FAIL dual_stack_shared_array_top");
      $finish;
   end

   // Out-of-range register values are clamped to the usable range.
   function automatic int live_entries();
      int e;
      e = int'(entries_reg);
      if (e < 1) e = 1;
      if (e > DEPTH) e = DEPTH;
      return e;
   endfunction

   // Even addresses ascending, then odd addresses descending.
   function automatic int snake_addr(int pos, int e);
      int evens;
      int top_odd;
      evens = (e + 1) / 2;
      if (pos < evens) return 2 * pos;
      top_odd = (e % 2 == 0) ? e - 1 : e - 2;
      return (top_odd - 2 * (pos - evens)) % DEPTH;
   endfunction

   function automatic dssa_pkg::rsp_type stacks_apply(dssa_pkg::req_type r);
      dssa_pkg::rsp_type res;
      int      e;
      int      pos;
      e = live_entries();
      res = '0;
      res.status = dssa_pkg::ST_OK;
      if (r.operation == dssa_pkg::OP_PUSH) begin
         if (depth_one + depth_two >= e) begin
            res.status = dssa_pkg::ST_OVERFLOW;
            overflow_count++;
         end else begin
            pos = (r.which_stack == dssa_pkg::STACK_TWO) ? e - 1 - depth_two : depth_one;
            shadow_store[snake_addr(pos, e)] = r.push_value;
            if (r.which_stack == dssa_pkg::STACK_TWO) depth_two++;
            else depth_one++;
         end
      end else begin
         if ((r.which_stack == dssa_pkg::STACK_TWO ? depth_two : depth_one) == 0) begin
            res.status = dssa_pkg::ST_UNDERFLOW;
            underflow_count++;
         end else begin
            if (r.which_stack == dssa_pkg::STACK_TWO) depth_two--;
            else depth_one--;
            pos = (r.which_stack == dssa_pkg::STACK_TWO) ? e - 1 - depth_two : depth_one;
            res.pop_value = shadow_store[snake_addr(pos, e)];
         end
      end
      return res;
   endfunction

   // Response checker; outputs are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h / %0d",
                     $realtime, rsp_data.pop_value, rsp_data.status);
            error_count++;
         end else begin
            dssa_pkg::rsp_type want;
            want = pending_results.pop_front();
            if (rsp_data.pop_value !== want.pop_value) begin
               $display("%0t: pop_value mismatch, expected %h, actual %h",
                        $realtime, want.pop_value, rsp_data.pop_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $realtime, want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Offers one request, waits for it to be taken, then idles at random.
   // start stays high when no idle cycle follows.
   task automatic send_request(logic op, logic stk, logic [31:0] value, int idle_pct);
      dssa_pkg::req_type item;
      item.operation   = op;
      item.which_stack = stk;
      item.push_value  = value;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(stacks_apply(item));
      request_count++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Called with start low; rewriting the count also empties both stacks.
   task automatic program_entries(logic [CW-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      entries_reg  = value;
      depth_one    = 0;
      depth_two    = 0;
      csr_write_count++;
   endtask

   function automatic logic [CW-1:0] pick_entries();
      int r;
      r = $urandom_range(99);
      if (r < 55) return CW'($urandom_range(1, 12));
      if (r < 65) return CW'(0);
      if (r < 73) return CW'(256);
      if (r < 80) return CW'($urandom_range(257, 511));
      if (r < 86) return CW'(255);
      return CW'($urandom_range(13, 254));
   endfunction

   task automatic test_edge_cases();
      program_entries(CW'(3));
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_TWO, 32'h0, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'h8000_0000, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_TWO, 32'h7FFF_FFFF, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'hFFFF_FFFF, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_TWO, 32'h0000_0000, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'h0000_0001, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_TWO, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      start <= 1'b0;
      // A count of zero behaves as a single entry.
      program_entries(CW'(0));
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_TWO, 32'h5A5A_A5A5, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'h1234_5678, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_TWO, 32'h0, 0);
      start <= 1'b0;
      program_entries(CW'(2));
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'hA5A5_5A5A, 0);
      send_request(dssa_pkg::OP_PUSH, dssa_pkg::STACK_ONE, 32'hDEAD_BEEF, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_TWO, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      send_request(dssa_pkg::OP_POP,  dssa_pkg::STACK_ONE, 32'h0, 0);
      start <= 1'b0;
   endtask

   // Values above the memory size act as the full memory.
   task automatic test_full_depth();
      program_entries(CW'(511));
      repeat (DEPTH + 2) begin
         send_request(dssa_pkg::OP_PUSH, 1'($urandom_range(1)), $urandom, 0);
      end
      repeat (DEPTH + 20) begin
         send_request(dssa_pkg::OP_POP, 1'($urandom_range(1)), 32'h0, 0);
      end
      start <= 1'b0;
   endtask

   // Bursts that lean toward pushes or pops so both full and empty are reached.
   task automatic test_random_traffic(int idle_pct, int segments, int per_segment);
      int left;
      int burst;
      int push_pct;
      int e;
      repeat (segments) begin
         program_entries(pick_entries());
         e    = live_entries();
         left = per_segment;
         while (left > 0) begin
            burst = $urandom_range(1, (2 * e + 2 > 40) ? 40 : 2 * e + 2);
            if (burst > left) burst = left;
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
            repeat (burst) begin
               send_request(($urandom_range(99) < push_pct) ? dssa_pkg::OP_PUSH
                                                            : dssa_pkg::OP_POP,
                            1'($urandom_range(1)), $urandom, idle_pct);
            end
            left -= burst;
         end
         start <= 1'b0;
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      entries_reg     = dssa_pkg::CSR_RESET;
      depth_one       = 0;
      depth_two       = 0;
      error_count     = 0;
      request_count   = 0;
      overflow_count  = 0;
      underflow_count = 0;
      csr_write_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_full_depth();
      test_random_traffic(0, 6, 80);
      test_random_traffic(80, 6, 80);
      test_random_traffic(24, 6, 80);

      wait_drained();
      repeat (4) @(posedge clock);
      $display("Covered %0d requests over %0d entry-count settings", request_count,
               csr_write_count);
      $display("with %0d overflows and %0d underflows; %0d mismatches", overflow_count,
               underflow_count, error_count);
      if (error_count == 0) begin
         $display("PASS dual_stack_shared_array_top");
      end else begin
         $display("FAIL dual_stack_shared_array_top");
      end
      $finish;
   end

endmodule
